FILE: design/snf_pkg.sv
// Shared types and constants for the neighbor finder unit.
// Used by every module of the block except snf_ram; depends on nothing.
package snf_pkg;

   localparam int MAX_CANDIDATES = 64;
   localparam int MIN_NEIGHBORS  = 3;
   localparam int ADDR_W         = $clog2(MAX_CANDIDATES);
   localparam int CNT_W          = $clog2(MAX_CANDIDATES + 1);
   localparam int ID_W           = 16;
   localparam int POS_W          = 32;
   localparam int MAG_W          = POS_W + 1;
   localparam int DIST_W         = 31;
   localparam int CFG_W          = 31;
   localparam int NCOUNT_W       = 7;
   localparam int SUM_W          = DIST_W + CNT_W;
   localparam int WORD_W         = ID_W + DIST_W;
   localparam int IN_TDATA_W     = ID_W + 3 * POS_W;
   localparam int OUT_FIELDS_W   = 2 * ID_W + DIST_W + NCOUNT_W;
   localparam int OUT_TDATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;
   localparam int FIFO_DEPTH     = 4;
   localparam int FIFO_AW        = $clog2(FIFO_DEPTH);

   // Command carried in tuser of the request channel.
   localparam logic CMD_CENTER    = 1'b0;
   localparam logic CMD_CANDIDATE = 1'b1;

   // Configuration register indexes.
   localparam logic CSR_BOX_SIZE = 1'b0;
   localparam logic CSR_CUTOFF   = 1'b1;

   typedef enum logic [1:0] {
      ST_EDGE     = 2'd0,
      ST_TOO_FEW  = 2'd1,
      ST_NOT_CONV = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   // One classified word handed from the front to the back.
   typedef struct packed {
      logic              is_center;
      logic [ID_W-1:0]   atom_id;
      logic [DIST_W-1:0] distance;
      logic              keep;
      logic              last;
   } entry_type;

endpackage

FILE: design/sann_neighbor_finder_unit.sv
// Top level of the solid-angle nearest neighbor finder.
// Depends on snf_pkg, snf_front, snf_fifo, snf_back (and snf_ram below it).
//
//   channel  direction  contents
//   req_     in         tuser command, tdata id and coordinates, tlast frame end
//   rsp_     out        tuser status, tdata edge fields, tlast last result of frame
//   csr_     in         write enable, register index, 31-bit data
//
// With a nonzero box a candidate word passes through the front in these steps:
// accept, a bit-serial modulo, fold, cutoff check, three squares, a bit-serial
// square root, keep decision and push. A zero box skips the modulo and the fold;
// an axis past the cutoff ends it after the check. A central word or a same-id
// candidate goes from accept straight to push.
// The back inserts by moving each larger stored entry up one place; the frame end
// pass sums the nearest distances, then alternates a check and a growth step, then
// emits the results. The store needs no clearing after reset.
// A four-word queue lets the front keep accepting while the back stalls on rsp_tready.
module sann_neighbor_finder_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic                            csr_index,
   input  logic [snf_pkg::CFG_W-1:0]       csr_wr_data,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // tdata: atom_id[15:0], pos_x[47:16], pos_y[79:48], pos_z[111:80]
   input  logic [snf_pkg::IN_TDATA_W-1:0]  req_tdata,
   // tuser: command
   input  logic                            req_tuser,
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // tdata: central_id[15:0], neighbor_id[31:16], neighbor_distance[62:32],
   //        neighbor_count[69:63], zero fill[71:70]
   output logic [snf_pkg::OUT_TDATA_W-1:0] rsp_tdata,
   // tuser: status[1:0]
   output snf_pkg::status_type             rsp_tuser,
   output logic                            rsp_tlast
);
   import snf_pkg::*;

   entry_type push_entry, pop_entry;
   logic      push_valid, fifo_full, pop, fifo_valid;

   snf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .push_valid  (push_valid),
      .push_entry  (push_entry),
      .fifo_full   (fifo_full)
   );

   snf_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_entry (push_entry),
      .full       (fifo_full),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .valid      (fifo_valid)
   );

   snf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (fifo_valid),
      .q_entry    (pop_entry),
      .q_pop      (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: design/snf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package needed.
module snf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read; read data holds while rd_en is low.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/snf_fifo.sv
// Short queue of classified words between the front and the back.
// Depends on snf_pkg for the word type and depth.
module snf_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  snf_pkg::entry_type  push_entry,
   output logic                full,
   input  logic                pop,
   output snf_pkg::entry_type  pop_entry,
   output logic                valid
);
   import snf_pkg::*;

   entry_type            slot_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]     fill_ff, fill_in;
   logic                 do_push, do_pop;

   assign full      = (fill_ff == (FIFO_AW+1)'(FIFO_DEPTH));
   assign valid     = (fill_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && valid;
   assign pop_entry = slot_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: design/snf_front.sv
// Front end: accepts request words, holds the central atom and configuration,
// and computes the periodic distance of each candidate. Depends on snf_pkg.
module snf_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic                          csr_index,
   input  logic [snf_pkg::CFG_W-1:0]     csr_wr_data,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [snf_pkg::IN_TDATA_W-1:0] req_tdata,
   input  logic                          req_tuser,
   input  logic                          req_tlast,
   output logic                          push_valid,
   output snf_pkg::entry_type            push_entry,
   input  logic                          fifo_full
);
   import snf_pkg::*;

   typedef enum logic [7:0] {
      F_IDLE = 8'b0000_0001,
      F_MOD  = 8'b0000_0010,
      F_FOLD = 8'b0000_0100,
      F_CHK  = 8'b0000_1000,
      F_SQ   = 8'b0001_0000,
      F_SQRT = 8'b0010_0000,
      F_KEEP = 8'b0100_0000,
      F_PUSH = 8'b1000_0000
   } fstate_type;

   fstate_type              state_ff, state_in;
   logic [CFG_W-1:0]        box_ff, box_in;
   logic [CFG_W-1:0]        cut_ff, cut_in;
   logic [ID_W-1:0]         ctr_id_ff, ctr_id_in;
   logic signed [POS_W-1:0] ctr_pos_ff [3];
   logic signed [POS_W-1:0] ctr_pos_in [3];
   entry_type               ent_ff, ent_in;
   logic [MAG_W-1:0]        mag_ff [3];
   logic [MAG_W-1:0]        mag_in [3];
   logic [POS_W-1:0]        rmod_ff [3];
   logic [POS_W-1:0]        rmod_in [3];
   logic [5:0]              step_ff, step_in;
   logic [1:0]              axis_ff, axis_in;
   logic [63:0]             sq_ff, sq_in;
   logic [34:0]             rem_ff, rem_in;
   logic [31:0]             root_ff, root_in;

   logic [ID_W-1:0]         in_id;
   logic signed [POS_W-1:0] in_pos [3];
   logic signed [MAG_W-1:0] delta [3];
   logic [MAG_W-1:0]        delta_abs [3];
   logic [POS_W-1:0]        mod_sh [3];
   logic [POS_W-1:0]        mod_nx [3];
   logic [MAG_W-1:0]        fold_nx [3];
   logic                    too_far;
   logic [DIST_W-1:0]       sq_sel;
   logic [2*DIST_W-1:0]     sq_prod;
   logic [34:0]             sqrt_sh, sqrt_trial;

   assign in_id      = req_tdata[ID_W-1:0];
   assign req_tready = (state_ff == F_IDLE);
   assign push_valid = (state_ff == F_PUSH);
   assign push_entry = ent_ff;
   assign sq_prod    = sq_sel * sq_sel;

   // Per-axis datapath: delta, one restoring modulo step, the fold and the cutoff test.
   always_comb begin
      too_far = 1'b0;
      for (int k = 0; k < 3; k++) begin
         in_pos[k]    = req_tdata[ID_W + k*POS_W +: POS_W];
         delta[k]     = {in_pos[k][POS_W-1], in_pos[k]}
                        - {ctr_pos_ff[k][POS_W-1], ctr_pos_ff[k]};
         delta_abs[k] = delta[k][MAG_W-1] ? MAG_W'(-delta[k]) : MAG_W'(delta[k]);
         mod_sh[k]    = {rmod_ff[k][POS_W-2:0], mag_ff[k][MAG_W-1]};
         mod_nx[k]    = (mod_sh[k] >= {1'b0, box_ff})
                        ? mod_sh[k] - {1'b0, box_ff} : mod_sh[k];
         fold_nx[k]   = ({rmod_ff[k], 1'b0} > {2'b00, box_ff})
                        ? {2'b00, box_ff - rmod_ff[k][DIST_W-1:0]}
                        : {1'b0, rmod_ff[k]};
         if (mag_ff[k] >= {2'b00, cut_ff}) begin
            too_far = 1'b1;
         end
      end
   end

   // Square-and-accumulate operand and the square root step.
   always_comb begin
      sq_sel = mag_ff[0][DIST_W-1:0];
      case (axis_ff)
         2'd1:    sq_sel = mag_ff[1][DIST_W-1:0];
         2'd2:    sq_sel = mag_ff[2][DIST_W-1:0];
         default: sq_sel = mag_ff[0][DIST_W-1:0];
      endcase
      sqrt_sh    = {rem_ff[32:0], sq_ff[63:62]};
      sqrt_trial = {1'b0, root_ff, 2'b01};
   end

   // Control sequence and next-state values.
   always_comb begin
      state_in  = state_ff;
      box_in    = box_ff;
      cut_in    = cut_ff;
      ctr_id_in = ctr_id_ff;
      ent_in    = ent_ff;
      step_in   = step_ff;
      axis_in   = axis_ff;
      sq_in     = sq_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      for (int k = 0; k < 3; k++) begin
         ctr_pos_in[k] = ctr_pos_ff[k];
         mag_in[k]     = mag_ff[k];
         rmod_in[k]    = rmod_ff[k];
      end

      if (csr_wr_en) begin
         if (csr_index == CSR_BOX_SIZE) begin
            box_in = csr_wr_data;
         end else begin
            cut_in = csr_wr_data;
         end
      end

      case (state_ff)
         F_IDLE: begin
            if (req_tvalid) begin
               ent_in.atom_id   = in_id;
               ent_in.last      = req_tlast;
               ent_in.is_center = (req_tuser == CMD_CENTER);
               ent_in.keep      = 1'b0;
               ent_in.distance  = '0;
               if (req_tuser == CMD_CENTER) begin
                  ctr_id_in = in_id;
                  for (int k = 0; k < 3; k++) begin
                     ctr_pos_in[k] = in_pos[k];
                  end
                  state_in = F_PUSH;
               end else if (in_id == ctr_id_ff) begin
                  state_in = F_PUSH;
               end else begin
                  for (int k = 0; k < 3; k++) begin
                     mag_in[k]  = delta_abs[k];
                     rmod_in[k] = '0;
                  end
                  step_in  = 6'(MAG_W - 1);
                  state_in = (box_ff == '0) ? F_CHK : F_MOD;
               end
            end
         end
         F_MOD: begin
            for (int k = 0; k < 3; k++) begin
               rmod_in[k] = mod_nx[k];
               mag_in[k]  = {mag_ff[k][MAG_W-2:0], 1'b0};
            end
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = F_FOLD;
            end
         end
         F_FOLD: begin
            for (int k = 0; k < 3; k++) begin
               mag_in[k] = fold_nx[k];
            end
            state_in = F_CHK;
         end
         F_CHK: begin
            if (too_far) begin
               state_in = F_PUSH;
            end else begin
               sq_in    = '0;
               axis_in  = '0;
               state_in = F_SQ;
            end
         end
         F_SQ: begin
            sq_in   = sq_ff + 64'(sq_prod);
            axis_in = axis_ff + 1'b1;
            if (axis_ff == 2'd2) begin
               rem_in   = '0;
               root_in  = '0;
               step_in  = 6'd31;
               state_in = F_SQRT;
            end
         end
         F_SQRT: begin
            if (sqrt_sh >= sqrt_trial) begin
               rem_in  = sqrt_sh - sqrt_trial;
               root_in = {root_ff[30:0], 1'b1};
            end else begin
               rem_in  = sqrt_sh;
               root_in = {root_ff[30:0], 1'b0};
            end
            sq_in   = {sq_ff[61:0], 2'b00};
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = F_KEEP;
            end
         end
         F_KEEP: begin
            ent_in.keep     = (root_ff < {1'b0, cut_ff});
            ent_in.distance = root_ff[DIST_W-1:0];
            state_in        = F_PUSH;
         end
         F_PUSH: begin
            if (!fifo_full) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= F_IDLE;
         box_ff    <= CFG_W'(655360);
         cut_ff    <= CFG_W'(360448);
         ctr_id_ff <= '0;
         for (int k = 0; k < 3; k++) begin
            ctr_pos_ff[k] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         box_ff    <= box_in;
         cut_ff    <= cut_in;
         ctr_id_ff <= ctr_id_in;
         for (int k = 0; k < 3; k++) begin
            ctr_pos_ff[k] <= ctr_pos_in[k];
         end
      end
   end

   // Datapath registers need no reset.
   always_ff @(posedge clock) begin
      ent_ff  <= ent_in;
      step_ff <= step_in;
      axis_ff <= axis_in;
      sq_ff   <= sq_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      for (int k = 0; k < 3; k++) begin
         mag_ff[k]  <= mag_in[k];
         rmod_ff[k] <= rmod_in[k];
      end
   end

endmodule

FILE: design/snf_back.sv
// Back end: sorted insertion into the candidate store, the radius growth
// pass at frame end, and the result register. Depends on snf_pkg, snf_ram.
module snf_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_valid,
   input  snf_pkg::entry_type              q_entry,
   output logic                            q_pop,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [snf_pkg::OUT_TDATA_W-1:0] rsp_tdata,
   output snf_pkg::status_type             rsp_tuser,
   output logic                            rsp_tlast
);
   import snf_pkg::*;

   typedef enum logic [8:0] {
      B_IDLE = 9'b0_0000_0001,
      B_INS  = 9'b0_0000_0010,
      B_INS0 = 9'b0_0000_0100,
      B_FIN  = 9'b0_0000_1000,
      B_SUM  = 9'b0_0001_0000,
      B_GCHK = 9'b0_0010_0000,
      B_GROW = 9'b0_0100_0000,
      B_EMIT = 9'b0_1000_0000,
      B_ERR  = 9'b1_0000_0000
   } bstate_type;

   bstate_type          state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                ovf_ff, ovf_in;
   logic [ID_W-1:0]     cid_ff, cid_in;
   logic [ID_W-1:0]     new_id_ff, new_id_in;
   logic [DIST_W-1:0]   new_dist_ff, new_dist_in;
   logic                last_ff, last_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic [CNT_W-1:0]    m_ff, m_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   status_type          err_ff, err_in;
   logic                rvalid_ff, rvalid_in;
   logic [ID_W-1:0]     r_cid_ff, r_cid_in;
   logic [ID_W-1:0]     r_nid_ff, r_nid_in;
   logic [DIST_W-1:0]   r_dist_ff, r_dist_in;
   status_type          r_st_ff, r_st_in;
   logic [NCOUNT_W-1:0] r_cnt_ff, r_cnt_in;
   logic                r_last_ff, r_last_in;

   logic                wr_en, rd_en;
   logic [ADDR_W-1:0]   wr_addr, rd_addr;
   logic [WORD_W-1:0]   wr_data, rd_data;
   logic [ID_W-1:0]     rd_id;
   logic [DIST_W-1:0]   rd_dist;
   logic [SUM_W-1:0]    prod;
   logic                out_free;

   snf_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_CANDIDATES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_id    = rd_data[WORD_W-1:DIST_W];
   assign rd_dist  = rd_data[DIST_W-1:0];
   // The radius divides by m - 2, so the test compares against d(m) * (m - 2).
   assign prod     = SUM_W'(rd_dist) * SUM_W'(m_ff - CNT_W'(2));
   assign out_free = !rvalid_ff || rsp_tready;

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tlast  = r_last_ff;
   assign rsp_tuser  = r_st_ff;
   assign rsp_tdata  = OUT_TDATA_W'({r_cnt_ff, r_dist_ff, r_nid_ff, r_cid_ff});

   // Frame sequencer.
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      ovf_in      = ovf_ff;
      cid_in      = cid_ff;
      new_id_in   = new_id_ff;
      new_dist_in = new_dist_ff;
      last_in     = last_ff;
      idx_in      = idx_ff;
      m_in        = m_ff;
      sum_in      = sum_ff;
      err_in      = err_ff;
      rvalid_in   = rvalid_ff && !rsp_tready;
      r_cid_in    = r_cid_ff;
      r_nid_in    = r_nid_ff;
      r_dist_in   = r_dist_ff;
      r_st_in     = r_st_ff;
      r_cnt_in    = r_cnt_ff;
      r_last_in   = r_last_ff;
      q_pop       = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = '0;
      wr_data     = {new_id_ff, new_dist_ff};
      rd_en       = 1'b0;
      rd_addr     = '0;

      case (state_ff)
         B_IDLE: begin
            q_pop = q_valid;
            if (q_valid) begin
               if (q_entry.is_center) begin
                  cid_in = q_entry.atom_id;
                  cnt_in = '0;
                  ovf_in = 1'b0;
               end else if (q_entry.keep) begin
                  if (cnt_ff >= CNT_W'(MAX_CANDIDATES)) begin
                     ovf_in = 1'b1;
                     if (q_entry.last) begin
                        state_in = B_FIN;
                     end
                  end else begin
                     new_id_in   = q_entry.atom_id;
                     new_dist_in = q_entry.distance;
                     last_in     = q_entry.last;
                     if (cnt_ff == '0) begin
                        wr_en   = 1'b1;
                        wr_data = {q_entry.atom_id, q_entry.distance};
                        cnt_in  = cnt_ff + 1'b1;
                        if (q_entry.last) begin
                           state_in = B_FIN;
                        end
                     end else begin
                        idx_in   = cnt_ff;
                        rd_en    = 1'b1;
                        rd_addr  = ADDR_W'(cnt_ff - 1'b1);
                        state_in = B_INS;
                     end
                  end
               end else if (q_entry.last) begin
                  state_in = B_FIN;
               end
            end
         end
         // Walk down from the top, moving larger entries up by one.
         B_INS: begin
            wr_en   = 1'b1;
            wr_addr = ADDR_W'(idx_ff);
            if (rd_dist > new_dist_ff) begin
               wr_data = rd_data;
               idx_in  = idx_ff - 1'b1;
               if (idx_ff == CNT_W'(1)) begin
                  state_in = B_INS0;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = ADDR_W'(idx_ff - CNT_W'(2));
               end
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = last_ff ? B_FIN : B_IDLE;
            end
         end
         B_INS0: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            cnt_in   = cnt_ff + 1'b1;
            state_in = last_ff ? B_FIN : B_IDLE;
         end
         B_FIN: begin
            if (ovf_ff) begin
               err_in   = ST_OVERFLOW;
               state_in = B_ERR;
            end else if (cnt_ff < CNT_W'(MIN_NEIGHBORS)) begin
               err_in   = ST_TOO_FEW;
               state_in = B_ERR;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = '0;
               idx_in   = '0;
               sum_in   = '0;
               state_in = B_SUM;
            end
         end
         // Sum of the nearest minimum set.
         B_SUM: begin
            sum_in = sum_ff + SUM_W'(rd_dist);
            if (idx_ff == CNT_W'(MIN_NEIGHBORS - 1)) begin
               m_in     = CNT_W'(MIN_NEIGHBORS);
               state_in = B_GCHK;
            end else begin
               idx_in  = idx_ff + 1'b1;
               rd_en   = 1'b1;
               rd_addr = ADDR_W'(idx_ff + 1'b1);
            end
         end
         B_GCHK: begin
            if (m_ff == cnt_ff) begin
               err_in   = ST_NOT_CONV;
               state_in = B_ERR;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = ADDR_W'(m_ff);
               state_in = B_GROW;
            end
         end
         // Grow while the radius exceeds the next distance.
         B_GROW: begin
            if (sum_ff > prod) begin
               sum_in   = sum_ff + SUM_W'(rd_dist);
               m_in     = m_ff + 1'b1;
               state_in = B_GCHK;
            end else begin
               idx_in   = '0;
               rd_en    = 1'b1;
               rd_addr  = '0;
               state_in = B_EMIT;
            end
         end
         B_EMIT: begin
            if (out_free) begin
               rvalid_in = 1'b1;
               r_cid_in  = cid_ff;
               r_nid_in  = rd_id;
               r_dist_in = rd_dist;
               r_st_in   = ST_EDGE;
               r_cnt_in  = NCOUNT_W'(m_ff);
               r_last_in = (idx_ff == m_ff - 1'b1);
               if (idx_ff == m_ff - 1'b1) begin
                  cnt_in   = '0;
                  ovf_in   = 1'b0;
                  state_in = B_IDLE;
               end else begin
                  idx_in  = idx_ff + 1'b1;
                  rd_en   = 1'b1;
                  rd_addr = ADDR_W'(idx_ff + 1'b1);
               end
            end
         end
         B_ERR: begin
            if (out_free) begin
               rvalid_in = 1'b1;
               r_cid_in  = cid_ff;
               r_nid_in  = '0;
               r_dist_in = '0;
               r_st_in   = err_ff;
               r_cnt_in  = '0;
               r_last_in = 1'b1;
               cnt_in    = '0;
               ovf_in    = 1'b0;
               state_in  = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= B_IDLE;
         cnt_ff    <= '0;
         ovf_ff    <= 1'b0;
         cid_ff    <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         ovf_ff    <= ovf_in;
         cid_ff    <= cid_in;
         rvalid_ff <= rvalid_in;
      end
   end

   // Datapath and result payload registers need no reset.
   always_ff @(posedge clock) begin
      new_id_ff   <= new_id_in;
      new_dist_ff <= new_dist_in;
      last_ff     <= last_in;
      idx_ff      <= idx_in;
      m_ff        <= m_in;
      sum_ff      <= sum_in;
      err_ff      <= err_in;
      r_cid_ff    <= r_cid_in;
      r_nid_ff    <= r_nid_in;
      r_dist_ff   <= r_dist_in;
      r_st_ff     <= r_st_in;
      r_cnt_ff    <= r_cnt_in;
      r_last_ff   <= r_last_in;
   end

endmodule
